[sv/dpvd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpvd_pkg
// Shared types and constants of the dual PID velocity controller: gain and
// deadband widths, register map, reset values and the stage enable bundle.
// ----------------------------------------------------------------------------
package dpvd_pkg;

    // fixed field widths of the register set
    localparam int GAIN_WIDTH      = 16;
    localparam int DEADBAND_WIDTH  = 15;
    localparam int CFG_INDEX_WIDTH = 4;
    localparam int CFG_DATA_WIDTH  = 16;

    // register map
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_P_LINEAR    = 4'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_I_LINEAR    = 4'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_D_LINEAR    = 4'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEADBAND_LINEAR  = 4'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_P_ANGULAR   = 4'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_I_ANGULAR   = 4'd5;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN_D_ANGULAR   = 4'd6;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEADBAND_ANGULAR = 4'd7;

    // reset values: gains Q4.12, deadbands unsigned Q7.8
    localparam logic signed [GAIN_WIDTH-1:0] RST_GAIN_P      = 16'sd2048;
    localparam logic signed [GAIN_WIDTH-1:0] RST_GAIN_I      = 16'sd0;
    localparam logic signed [GAIN_WIDTH-1:0] RST_GAIN_D      = 16'sd410;
    localparam logic [DEADBAND_WIDTH-1:0]    RST_DEADBAND_LIN = 15'd26;
    localparam logic [DEADBAND_WIDTH-1:0]    RST_DEADBAND_ANG = 15'd0;

    // per-channel coefficient set
    typedef struct packed {
        logic signed [GAIN_WIDTH-1:0] gain_p;
        logic signed [GAIN_WIDTH-1:0] gain_i;
        logic signed [GAIN_WIDTH-1:0] gain_d;
        logic [DEADBAND_WIDTH-1:0]    deadband;
    } chan_cfg_t;

    // load enables of the three pipeline stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } stage_en_t;

endpackage

[sv/dpvd_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpvd_cfg_regs
// Coefficient register file: gains and deadbands of both channels, written
// through the configuration port, one register per transaction.
// ----------------------------------------------------------------------------
module dpvd_cfg_regs (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [dpvd_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [dpvd_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
    output dpvd_pkg::chan_cfg_t                   cfg_linear,
    output dpvd_pkg::chan_cfg_t                   cfg_angular
);
    import dpvd_pkg::*;

    chan_cfg_t lin_reg, lin_next;
    chan_cfg_t ang_reg, ang_next;
    logic      wr_en;

    // writes never stall
    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid & cfg_ready;

    // register decode, indexes beyond the map are dropped
    always_comb begin
        lin_next = lin_reg;
        ang_next = ang_reg;
        if (wr_en) begin
            case (cfg_index)
                REG_GAIN_P_LINEAR:    lin_next.gain_p   = cfg_data;
                REG_GAIN_I_LINEAR:    lin_next.gain_i   = cfg_data;
                REG_GAIN_D_LINEAR:    lin_next.gain_d   = cfg_data;
                REG_DEADBAND_LINEAR:  lin_next.deadband = cfg_data[DEADBAND_WIDTH-1:0];
                REG_GAIN_P_ANGULAR:   ang_next.gain_p   = cfg_data;
                REG_GAIN_I_ANGULAR:   ang_next.gain_i   = cfg_data;
                REG_GAIN_D_ANGULAR:   ang_next.gain_d   = cfg_data;
                REG_DEADBAND_ANGULAR: ang_next.deadband = cfg_data[DEADBAND_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lin_reg.gain_p   <= RST_GAIN_P;
            lin_reg.gain_i   <= RST_GAIN_I;
            lin_reg.gain_d   <= RST_GAIN_D;
            lin_reg.deadband <= RST_DEADBAND_LIN;
            ang_reg.gain_p   <= RST_GAIN_P;
            ang_reg.gain_i   <= RST_GAIN_I;
            ang_reg.gain_d   <= RST_GAIN_D;
            ang_reg.deadband <= RST_DEADBAND_ANG;
        end else begin
            lin_reg <= lin_next;
            ang_reg <= ang_next;
        end
    end

    assign cfg_linear  = lin_reg;
    assign cfg_angular = ang_reg;

endmodule

[sv/dpvd_channel.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpvd_channel
// One PID channel: error, saturating integral and derivative in the first
// stage, the three gain products in the second, sum, scaling, saturation and
// deadband in the third.
// ----------------------------------------------------------------------------
module dpvd_channel #(
    parameter int DATA_WIDTH     = 16,
    parameter int GAIN_FRAC_BITS = 12,
    parameter int ACC_WIDTH      = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  dpvd_pkg::stage_en_t           en,
    input  dpvd_pkg::chan_cfg_t           cfg,
    input  logic signed [DATA_WIDTH-1:0]  target,
    input  logic signed [DATA_WIDTH-1:0]  measured,
    output logic signed [DATA_WIDTH-1:0]  drive
);
    import dpvd_pkg::*;

    localparam int ERR_W = DATA_WIDTH + 1;
    localparam int DER_W = DATA_WIDTH + 2;
    localparam int INT_W = ((ACC_WIDTH > ERR_W) ? ACC_WIDTH : ERR_W) + 1;
    localparam int PP_W  = GAIN_WIDTH + ERR_W;
    localparam int PI_W  = GAIN_WIDTH + ACC_WIDTH;
    localparam int PD_W  = GAIN_WIDTH + DER_W;
    localparam int BIG_W = (ACC_WIDTH > DER_W) ? ACC_WIDTH : DER_W;
    localparam int SUM_W = GAIN_WIDTH + BIG_W + 2;
    localparam int CMP_W = (ERR_W > DEADBAND_WIDTH) ? ERR_W : DEADBAND_WIDTH;

    localparam logic signed [INT_W-1:0] INT_MAX =
        INT_W'({1'b0, {(ACC_WIDTH-1){1'b1}}});
    localparam logic signed [INT_W-1:0] INT_MIN = ~INT_MAX;
    localparam logic signed [SUM_W-1:0] OUT_MAX =
        SUM_W'({1'b0, {(DATA_WIDTH-1){1'b1}}});
    localparam logic signed [SUM_W-1:0] OUT_MIN = ~OUT_MAX;

    // loop state
    logic signed [ACC_WIDTH-1:0] integral_reg, integral_next;
    logic signed [ERR_W-1:0]     last_err_reg;

    // stage 1
    logic signed [ERR_W-1:0]     err_next, err_s1_reg;
    logic signed [INT_W-1:0]     int_sum;
    logic signed [ACC_WIDTH-1:0] integ_s1_reg;
    logic signed [DER_W-1:0]     der_next, der_s1_reg;
    logic [ERR_W-1:0]            mag;
    logic                        dead_next, dead_s1_reg;

    // stage 2
    logic signed [PP_W-1:0]      prod_p_next, prod_p_reg;
    logic signed [PI_W-1:0]      prod_i_next, prod_i_reg;
    logic signed [PD_W-1:0]      prod_d_next, prod_d_reg;
    logic                        dead_s2_reg;

    // stage 3
    logic signed [SUM_W-1:0]      sum, shifted;
    logic signed [DATA_WIDTH-1:0] drive_next, drive_reg;

    // error, saturating integral, derivative and deadband test
    always_comb begin
        err_next = ERR_W'(target) - ERR_W'(measured);
        int_sum  = INT_W'(integral_reg) + INT_W'(err_next);
        if (int_sum > INT_MAX) begin
            integral_next = INT_MAX[ACC_WIDTH-1:0];
        end else if (int_sum < INT_MIN) begin
            integral_next = INT_MIN[ACC_WIDTH-1:0];
        end else begin
            integral_next = int_sum[ACC_WIDTH-1:0];
        end
        der_next  = DER_W'(err_next) - DER_W'(last_err_reg);
        mag       = err_next[ERR_W-1] ? ERR_W'(~err_next + 1'b1) : ERR_W'(err_next);
        dead_next = CMP_W'(mag) < CMP_W'(cfg.deadband);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integral_reg <= '0;
            last_err_reg <= '0;
        end else if (en.s1) begin
            integral_reg <= integral_next;
            last_err_reg <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            err_s1_reg   <= err_next;
            integ_s1_reg <= integral_next;
            der_s1_reg   <= der_next;
            dead_s1_reg  <= dead_next;
        end
    end

    // gain products
    always_comb begin
        prod_p_next = PP_W'(cfg.gain_p) * PP_W'(err_s1_reg);
        prod_i_next = PI_W'(cfg.gain_i) * PI_W'(integ_s1_reg);
        prod_d_next = PD_W'(cfg.gain_d) * PD_W'(der_s1_reg);
    end

    always_ff @(posedge aclk) begin
        if (en.s2) begin
            prod_p_reg  <= prod_p_next;
            prod_i_reg  <= prod_i_next;
            prod_d_reg  <= prod_d_next;
            dead_s2_reg <= dead_s1_reg;
        end
    end

    // sum, floor scaling, output saturation and deadband
    always_comb begin
        sum     = SUM_W'(prod_p_reg) + SUM_W'(prod_i_reg) + SUM_W'(prod_d_reg);
        shifted = sum >>> GAIN_FRAC_BITS;
        if (dead_s2_reg) begin
            drive_next = '0;
        end else if (shifted > OUT_MAX) begin
            drive_next = OUT_MAX[DATA_WIDTH-1:0];
        end else if (shifted < OUT_MIN) begin
            drive_next = OUT_MIN[DATA_WIDTH-1:0];
        end else begin
            drive_next = shifted[DATA_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s3) begin
            drive_reg <= drive_next;
        end
    end

    assign drive = drive_reg;

endmodule

[sv/dual_pid_velocity_deadband.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_pid_velocity_deadband
// Two independent discrete PID controllers (linear and angular) with a
// saturating integral, floor scaling by the gain fraction and a deadband.
// ----------------------------------------------------------------------------
// The block accepts one transaction per clock unless a stalled output has
// filled the pipeline, and each result passes through the three-stage
// pipeline (error and integral update, gain products, sum and saturation)
// before it is returned. The integral and previous error are updated in the
// first stage at acceptance, so consecutive transactions follow each other
// without gaps. A stalled output fills the pipeline before input is held off.
// Coefficients are written through the configuration port, one register per
// transaction with no stall, and should only change while the block is idle.
module dual_pid_velocity_deadband #(
    parameter int DATA_WIDTH     = 16,
    parameter int GAIN_FRAC_BITS = 12,
    parameter int ACC_WIDTH      = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [dpvd_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [dpvd_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [DATA_WIDTH-1:0]          s_target_linear,
    input  logic signed [DATA_WIDTH-1:0]          s_measured_linear,
    input  logic signed [DATA_WIDTH-1:0]          s_target_angular,
    input  logic signed [DATA_WIDTH-1:0]          s_measured_angular,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [DATA_WIDTH-1:0]          m_drive_linear,
    output logic signed [DATA_WIDTH-1:0]          m_drive_angular
);
    import dpvd_pkg::*;

    chan_cfg_t cfg_linear, cfg_angular;
    stage_en_t en;

    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic v3_reg, v3_next;
    logic adv3, rdy2, take1, take2, accept;

    // coefficient registers
    dpvd_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cfg_linear  (cfg_linear),
        .cfg_angular (cfg_angular)
    );

    // pipeline flow control, each stage moves when the next has room
    always_comb begin
        adv3    = !v3_reg || m_ready;
        take2   = v2_reg && adv3;
        rdy2    = !v2_reg || adv3;
        take1   = v1_reg && rdy2;
        s_ready = !v1_reg || rdy2;
        accept  = s_valid && s_ready;

        v1_next = accept ? 1'b1 : (take1 ? 1'b0 : v1_reg);
        v2_next = take1  ? 1'b1 : (take2 ? 1'b0 : v2_reg);
        v3_next = take2  ? 1'b1 : (m_ready ? 1'b0 : v3_reg);

        en.s1 = accept;
        en.s2 = take1;
        en.s3 = take2;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    assign m_valid = v3_reg;

    // linear channel
    dpvd_channel #(
        .DATA_WIDTH     (DATA_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .ACC_WIDTH      (ACC_WIDTH)
    ) u_linear (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .cfg      (cfg_linear),
        .target   (s_target_linear),
        .measured (s_measured_linear),
        .drive    (m_drive_linear)
    );

    // angular channel
    dpvd_channel #(
        .DATA_WIDTH     (DATA_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .ACC_WIDTH      (ACC_WIDTH)
    ) u_angular (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .cfg      (cfg_angular),
        .target   (s_target_angular),
        .measured (s_measured_angular),
        .drive    (m_drive_angular)
    );

endmodule

[sv/dpvd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpvd_checker
// Port-level checks of the dual PID controller: reset, output hold under
// stall, pipeline latency and input readiness.
// ----------------------------------------------------------------------------
module dpvd_checker #(
    parameter int DATA_WIDTH = 16
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          cfg_ready,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic signed [DATA_WIDTH-1:0]  m_drive_linear,
    input logic signed [DATA_WIDTH-1:0]  m_drive_angular
);

    // no result straight after reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_drive_linear)
            && $stable(m_drive_angular))
        else $error("stalled result changed or dropped");

    // with the output side ready an accepted transaction emerges once it has passed the v1, v2 and v3 valid registers
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready ##1 m_ready ##1 m_ready |=> m_valid)
        else $error("result missing three cycles after acceptance");

    // an open output side never holds off input or configuration
    a_ready_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready && cfg_ready)
        else $error("input held off while output ready");

endmodule

bind dual_pid_velocity_deadband dpvd_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_dpvd_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .cfg_ready       (cfg_ready),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_drive_linear  (m_drive_linear),
    .m_drive_angular (m_drive_angular)
);
